// ===== rtl/assert_macros.svh =====
// assertion helpers for the cipher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== rtl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

  typedef logic [15:0][7:0] blk_t;  // index i is block byte i

  typedef struct packed {
    logic valid;
    logic cmd;
  } ctrl_t;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [7:0] REG_KEY_HIGH = 8'd0;
  localparam logic [7:0] REG_KEY_LOW  = 8'd1;

  localparam int NROUNDS = 10;
  localparam logic [3:0] KEY_SETTLE = 4'd10;

  localparam logic [7:0] RCON [NROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    rotl8 = (v << n) | (v >> (8 - n));
  endfunction

  // linear part of the inverse affine map
  function automatic logic [7:0] ainv_lin(input logic [7:0] v);
    ainv_lin = rotl8(v, 1) ^ rotl8(v, 3) ^ rotl8(v, 6);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    sbox = SBOX[x];
  endfunction

  // field inverse recovered from the forward table: inv(b) = Ainv(S(b)) ^ 05
  function automatic logic [7:0] inv_sbox(input logic [7:0] y);
    logic [7:0] b;
    b = ainv_lin(y) ^ 8'h05;
    inv_sbox = ainv_lin(SBOX[b]) ^ 8'h05;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t to_blk(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] w;
    blk_t b;
    w = {hi, lo};
    for (int i = 0; i < 16; i++) b[i] = w[127 - 8 * i -: 8];
    to_blk = b;
  endfunction

  function automatic logic [127:0] from_blk(input blk_t b);
    logic [127:0] w;
    for (int i = 0; i < 16; i++) w[127 - 8 * i -: 8] = b[i];
    from_blk = w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_ifs.sv =====
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, command, block_high, block_low, input ready);
  modport sink (input valid, command, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/aes_key_cell.sv =====
`default_nettype none
module aes_key_cell (
  input  wire logic         clk,
  input  wire aes_pkg::blk_t key_prev,
  input  wire logic [7:0]   rcon,
  output aes_pkg::blk_t     key
);
  import aes_pkg::*;

  blk_t key_next;

  always_comb begin
    logic [3:0][7:0] t;
    t[0] = sbox(key_prev[13]) ^ rcon;
    t[1] = sbox(key_prev[14]);
    t[2] = sbox(key_prev[15]);
    t[3] = sbox(key_prev[12]);
    for (int k = 0; k < 4; k++) begin
      key_next[k]      = key_prev[k] ^ t[k];
      key_next[4 + k]  = key_prev[4 + k] ^ key_next[k];
      key_next[8 + k]  = key_prev[8 + k] ^ key_next[4 + k];
      key_next[12 + k] = key_prev[12 + k] ^ key_next[8 + k];
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end
endmodule
`default_nettype wire

// ===== rtl/aes_round_cell.sv =====
`default_nettype none
module aes_round_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          last,
  input  wire aes_pkg::ctrl_t ctrl_prev,
  input  wire aes_pkg::blk_t  state_prev,
  input  wire aes_pkg::blk_t  key_enc,
  input  wire aes_pkg::blk_t  key_dec,
  output aes_pkg::ctrl_t      ctrl,
  output aes_pkg::blk_t       state
);
  import aes_pkg::*;

  blk_t state_next;

  always_comb begin
    blk_t sh, sb, ak, mx;
    logic [7:0] a2, a4, a8, a9, ab, ad, ae;
    int src;
    sh = '0;
    sb = '0;
    ak = '0;
    mx = '0;
    a2 = '0;
    a4 = '0;
    a8 = '0;
    a9 = '0;
    ab = '0;
    ad = '0;
    ae = '0;
    src = 0;
    if (ctrl_prev.cmd == CMD_ENCRYPT) begin
      for (int i = 0; i < 16; i++) sb[i] = sbox(state_prev[i]);
      sh = sb;
      for (int r = 1; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          src = r + 4 * ((c + r) % 4);
          sh[r + 4 * c] = sb[src];
        end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) begin
          mx[4 * c + r] = xt(sh[4 * c + r]) ^ xt(sh[4 * c + (r + 1) % 4])
                        ^ sh[4 * c + (r + 1) % 4] ^ sh[4 * c + (r + 2) % 4]
                        ^ sh[4 * c + (r + 3) % 4];
        end
      state_next = (last ? sh : mx) ^ key_enc;
    end else begin
      sh = state_prev;
      for (int r = 1; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          src = r + 4 * ((c + r) % 4);
          sh[src] = state_prev[r + 4 * c];
        end
      for (int i = 0; i < 16; i++) sb[i] = inv_sbox(sh[i]);
      ak = sb ^ key_dec;
      mx = ak;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) begin
          mx[4 * c + r] = 8'h00;
          for (int k = 0; k < 4; k++) begin
            a2 = xt(ak[4 * c + k]);
            a4 = xt(a2);
            a8 = xt(a4);
            a9 = a8 ^ ak[4 * c + k];
            ab = a9 ^ a2;
            ad = a9 ^ a4;
            ae = a8 ^ a4 ^ a2;
            case ((k - r + 4) % 4)
              0:       mx[4 * c + r] = mx[4 * c + r] ^ ae;
              1:       mx[4 * c + r] = mx[4 * c + r] ^ ab;
              2:       mx[4 * c + r] = mx[4 * c + r] ^ ad;
              default: mx[4 * c + r] = mx[4 * c + r] ^ a9;
            endcase
          end
        end
      state_next = last ? ak : mx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= ctrl_prev.valid;
    end
    if (en) begin
      ctrl.cmd <= ctrl_prev.cmd;
      state    <= state_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/aes128_block_cipher.sv =====
// channel | dir | payload                          | handshake
// cfg     | in  | index (0 key_high, 1 key_low), data | valid/ready
// in_ch   | in  | command, block_high, block_low   | valid/ready
// out_ch  | out | result_high, result_low          | valid/ready
// Ten registered round cells in a row, one block per cycle when not stalled.
// A parallel chain of ten key cells registers the round keys.
// After reset or a key write, input ready stays low while the key chain
// settles. An output stall freezes the round cells; the key cells run on.
`default_nettype none
`include "assert_macros.svh"
module aes128_block_cipher (
  input  wire logic clk,
  input  wire logic rst,
  aes_cfg_if.sink   cfg,
  aes_in_if.sink    in_ch,
  aes_out_if.source out_ch
);
  import aes_pkg::*;

  logic [63:0]  key_high, key_low;
  logic [3:0]   settle;
  blk_t         rk [NROUNDS + 1];
  ctrl_t        ctrl [NROUNDS + 1];
  blk_t         st   [NROUNDS + 1];
  logic         en, cfg_fire, in_fire;
  logic [127:0] res_w;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid & cfg.ready;
  assign en        = ~ctrl[NROUNDS].valid | out_ch.ready;
  assign in_ch.ready = en & (settle == 4'd0);
  assign in_fire   = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      settle   <= KEY_SETTLE;
    end else if (cfg_fire) begin
      if (cfg.index == REG_KEY_HIGH) key_high <= cfg.data;
      if (cfg.index == REG_KEY_LOW)  key_low  <= cfg.data;
      settle <= KEY_SETTLE;
    end else if (settle != 4'd0) begin
      settle <= settle - 4'd1;
    end
  end

  assign rk[0] = to_blk(key_high, key_low);

  for (genvar j = 1; j <= NROUNDS; j++) begin : g_key
    aes_key_cell u_key (
      .clk(clk), .key_prev(rk[j - 1]), .rcon(RCON[j - 1]), .key(rk[j])
    );
  end

  // entry: initial key add
  assign ctrl[0].valid = in_fire;
  assign ctrl[0].cmd   = in_ch.command;
  assign st[0] = to_blk(in_ch.block_high, in_ch.block_low)
               ^ ((in_ch.command == CMD_ENCRYPT) ? rk[0] : rk[NROUNDS]);

  for (genvar j = 1; j <= NROUNDS; j++) begin : g_round
    aes_round_cell u_round (
      .clk(clk), .rst(rst), .en(en), .last(j == NROUNDS),
      .ctrl_prev(ctrl[j - 1]), .state_prev(st[j - 1]),
      .key_enc(rk[j]), .key_dec(rk[NROUNDS - j]),
      .ctrl(ctrl[j]), .state(st[j])
    );
  end

  assign res_w              = from_blk(st[NROUNDS]);
  assign out_ch.valid       = ctrl[NROUNDS].valid;
  assign out_ch.result_high = res_w[127:64];
  assign out_ch.result_low  = res_w[63:0];

  `ASSERT_NEXT(a_cfg_blocks_input, clk, rst, cfg_fire, !in_ch.ready)
  `ASSERT_NEXT(a_keys_settled, clk, rst, (settle == 4'd0) && !cfg_fire,
               $stable(rk[NROUNDS]))
  `ASSERT_NEXT(a_stall_holds, clk, rst, out_ch.valid && !out_ch.ready,
               out_ch.valid && $stable(out_ch.result_low))
endmodule
`default_nettype wire
